/* hw/rtl/efwd_pkg.sv */
// shared types and constants for the escaped frame word deframer
package efwd_pkg;

  // framing bytes
  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] ESC_BYTE   = 8'hBB;
  localparam logic [7:0] STOP_BYTE  = 8'hCC;
  localparam logic [7:0] SUM_INVERT = 8'hFF;

  // value limit register
  localparam int unsigned     LIMIT_W     = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP   = 7'd64;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd40;

  // result field widths
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned STATUS_W = 2;

  // frame-end status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SUM_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LEN_FAIL = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

  // byte class found by the front end
  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_START,
    KIND_ESC,
    KIND_STOP
  } kind_t;

  // one classified byte as held in the queue
  typedef struct packed {
    logic [7:0] rx_byte;
    kind_t      kind;
  } item_t;

endpackage

/* hw/rtl/efwd_front.sv */
// front end: accepts received bytes, classifies them and queues them
module efwd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              q_valid,
  output efwd_pkg::item_t   q_item,
  input  logic              q_pop
);

  efwd_pkg::item_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  efwd_pkg::item_t new_item;
  logic            push;

  // classify the incoming byte
  always_comb begin
    new_item.rx_byte = in_rx_byte;
    if (in_rx_byte == efwd_pkg::START_BYTE) begin
      new_item.kind = efwd_pkg::KIND_START;
    end else if (in_rx_byte == efwd_pkg::ESC_BYTE) begin
      new_item.kind = efwd_pkg::KIND_ESC;
    end else if (in_rx_byte == efwd_pkg::STOP_BYTE) begin
      new_item.kind = efwd_pkg::KIND_STOP;
    end else begin
      new_item.kind = efwd_pkg::KIND_DATA;
    end
  end

  // two-entry queue control
  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

/* hw/rtl/efwd_back.sv */
// back end: frame state machine, checksum, word assembly and result register
module efwd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [efwd_pkg::LIMIT_W-1:0]   cfg_wr_data,
  input  logic                           q_valid,
  input  efwd_pkg::item_t                q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [efwd_pkg::VALUE_W-1:0]   out_word_value,
  output logic [efwd_pkg::INDEX_W-1:0]   out_word_index,
  output logic                           out_frame_end,
  output logic [efwd_pkg::STATUS_W-1:0]  out_frame_status
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic                            esc_r, esc_nxt;
  logic                            odd_r, odd_nxt;
  logic [7:0]                      prev_r, prev_nxt;
  logic [7:0]                      sum_r, sum_nxt;
  logic [efwd_pkg::LIMIT_W-1:0]    adv_r, adv_nxt;
  logic [efwd_pkg::LIMIT_W-1:0]    rcv_r, rcv_nxt;
  logic [efwd_pkg::LIMIT_W-1:0]    limit_r;
  logic [efwd_pkg::LIMIT_W-1:0]    limit_eff;
  logic [7:0]                      data_byte;
  logic [7:0]                      rx_sum;

  logic                            res_valid;
  logic [efwd_pkg::VALUE_W-1:0]    res_value;
  logic [efwd_pkg::INDEX_W-1:0]    res_index;
  logic                            res_end;
  logic [efwd_pkg::STATUS_W-1:0]   res_status;

  logic                            out_valid_r, out_valid_nxt;
  logic [efwd_pkg::VALUE_W-1:0]    value_r;
  logic [efwd_pkg::INDEX_W-1:0]    index_r;
  logic                            end_r;
  logic [efwd_pkg::STATUS_W-1:0]   status_r;

  // take a queued byte whenever the result register can move
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  assign limit_eff = (limit_r > efwd_pkg::LIMIT_CAP) ? efwd_pkg::LIMIT_CAP : limit_r;
  assign data_byte = esc_r ? (q_item.rx_byte ^ efwd_pkg::ESC_BYTE) : q_item.rx_byte;
  assign rx_sum    = esc_r ? (prev_r ^ efwd_pkg::SUM_INVERT) : prev_r;

  // per-byte frame update
  always_comb begin
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    odd_nxt    = odd_r;
    prev_nxt   = q_item.rx_byte;
    sum_nxt    = sum_r;
    adv_nxt    = adv_r;
    rcv_nxt    = rcv_r;
    res_valid  = 1'b0;
    res_value  = '0;
    res_index  = '0;
    res_end    = 1'b0;
    res_status = efwd_pkg::STATUS_OK;
    unique case (phase_r)
      PH_HUNT: begin
        if (q_item.kind == efwd_pkg::KIND_START) begin
          phase_nxt = PH_LEN;
          esc_nxt   = 1'b0;
          odd_nxt   = 1'b0;
          sum_nxt   = '0;
          adv_nxt   = '0;
          rcv_nxt   = '0;
        end
      end
      PH_LEN: begin
        sum_nxt   = q_item.rx_byte;
        adv_nxt   = q_item.rx_byte[7:1];
        phase_nxt = PH_BODY;
      end
      PH_BODY: begin
        priority if (q_item.kind == efwd_pkg::KIND_ESC) begin
          esc_nxt = 1'b1;
        end else if (q_item.kind == efwd_pkg::KIND_STOP) begin
          res_valid = 1'b1;
          res_end   = 1'b1;
          if (rx_sum != sum_r) begin
            res_status = efwd_pkg::STATUS_SUM_FAIL;
          end else if (rcv_r != adv_r) begin
            res_status = efwd_pkg::STATUS_LEN_FAIL;
          end else begin
            res_status = efwd_pkg::STATUS_OK;
          end
          phase_nxt = PH_HUNT;
          esc_nxt   = 1'b0;
          odd_nxt   = 1'b0;
        end else begin
          esc_nxt  = 1'b0;
          prev_nxt = data_byte;
          if (odd_r) begin
            res_valid = 1'b1;
            odd_nxt   = 1'b0;
            if (rcv_r >= limit_eff) begin
              // too many values: abort the frame
              res_end    = 1'b1;
              res_status = efwd_pkg::STATUS_OVERFLOW;
              phase_nxt  = PH_HUNT;
            end else begin
              sum_nxt   = sum_r + data_byte + prev_r;
              res_value = {prev_r, data_byte};
              res_index = rcv_r[efwd_pkg::INDEX_W-1:0];
              rcv_nxt   = rcv_r + 7'd1;
            end
          end else begin
            odd_nxt = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // result register valid
  always_comb begin
    if (q_pop) begin
      out_valid_nxt = res_valid;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state, limit register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      esc_r       <= 1'b0;
      odd_r       <= 1'b0;
      prev_r      <= '0;
      sum_r       <= '0;
      adv_r       <= '0;
      rcv_r       <= '0;
      limit_r     <= efwd_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
      value_r     <= '0;
      index_r     <= '0;
      end_r       <= 1'b0;
      status_r    <= efwd_pkg::STATUS_OK;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        esc_r   <= esc_nxt;
        odd_r   <= odd_nxt;
        prev_r  <= prev_nxt;
        sum_r   <= sum_nxt;
        adv_r   <= adv_nxt;
        rcv_r   <= rcv_nxt;
      end
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
      // result payload
      if (q_pop && res_valid) begin
        value_r  <= res_value;
        index_r  <= res_index;
        end_r    <= res_end;
        status_r <= res_status;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_word_value   = value_r;
  assign out_word_index   = index_r;
  assign out_frame_end    = end_r;
  assign out_frame_status = status_r;

endmodule

/* hw/rtl/escaped_frame_word_deframer_core.sv */
// top level of the escaped frame word deframer
// Takes one received byte per cycle while in_stall is low, hunts for frames
// opened by 0xAA, unstuffs bytes escaped by 0xBB, and returns each big-endian
// 16-bit word with its index, then one frame-end status word on 0xCC (ok,
// checksum fail, length fail) or an overflow abort once the configured value
// limit is passed. The back end sets the rate: it updates the frame state once
// per byte and pops a byte whenever its result register is free or being taken.
// A two-entry byte queue separates intake from result delivery, and a result is
// registered as its byte is popped. The user must write the value limit (reset 40,
// above 64 acts as 64) only while the block is idle; the block does not enforce it.
module escaped_frame_word_deframer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [efwd_pkg::LIMIT_W-1:0]   cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [efwd_pkg::VALUE_W-1:0]   out_word_value,
  output logic [efwd_pkg::INDEX_W-1:0]   out_word_index,
  output logic                           out_frame_end,
  output logic [efwd_pkg::STATUS_W-1:0]  out_frame_status
);

  logic            q_valid;
  logic            q_pop;
  efwd_pkg::item_t q_item;

  // byte intake and queue
  efwd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // frame processing and results
  efwd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word_value   (out_word_value),
    .out_word_index   (out_word_index),
    .out_frame_end    (out_frame_end),
    .out_frame_status (out_frame_status)
  );

endmodule
